/* design/lsps_pkg.sv */
// ----------------------------------------------------------------------------
// LED strip pattern sequencer package
// Field widths, register map, reset values and the phase encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsps_pkg;

    // Field widths
    localparam int COLOR_W  = 24;
    localparam int INDEX_W  = 8;
    localparam int LIGHTS_W = 9;
    localparam int BLOCK_W  = 9;
    localparam int BCOUNT_W = 8;
    localparam int BFRAME_W = 8;
    localparam int END_W    = 16;
    localparam int FRAME_W  = 17;

    // APB port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_NUM_LIGHTS  = 3'd0;
    localparam logic [2:0] REG_BLOCK_LEFT  = 3'd1;
    localparam logic [2:0] REG_BLOCK_RIGHT = 3'd2;
    localparam logic [2:0] REG_BLINK_COUNT = 3'd3;
    localparam logic [2:0] REG_BLINK_FRAME = 3'd4;
    localparam logic [2:0] REG_END_FRAMES  = 3'd5;

    // Register reset values
    localparam logic [LIGHTS_W-1:0] RST_NUM_LIGHTS  = 9'd64;
    localparam logic [BLOCK_W-1:0]  RST_BLOCK_LEFT  = 9'd3;
    localparam logic [BLOCK_W-1:0]  RST_BLOCK_RIGHT = 9'd3;
    localparam logic [BCOUNT_W-1:0] RST_BLINK_COUNT = 8'd4;
    localparam logic [BFRAME_W-1:0] RST_BLINK_FRAME = 8'd8;
    localparam logic [END_W-1:0]    RST_END_FRAMES  = 16'd16;

    // Pattern phases
    typedef enum logic [6:0] {
        PH_LEFT   = 7'b0000001,
        PH_RIGHT  = 7'b0000010,
        PH_FILL_L = 7'b0000100,
        PH_CROSS  = 7'b0001000,
        PH_FILL_R = 7'b0010000,
        PH_BLINK  = 7'b0100000,
        PH_END    = 7'b1000000
    } t_phase;

endpackage

/* design/led_strip_pattern_sequencer_top.sv */
// ----------------------------------------------------------------------------
// LED strip pattern sequencer
// Output: a result is registered and valid in the cycle after its input transfer.
// Throughput: one light per cycle; the single output register is the only
//   stage, and a new transfer is taken whenever it is empty or being drained.
// Reset: synchronous, active low; clears the sequencer counters, loads the
//   register defaults and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_strip_pattern_sequencer_top #(
    parameter int MAX_LIGHTS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [23:0] on_color, [47:24] off_color
    input  logic [47:0]                  s_axis_tdata,
    // Output stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] light_index, [31:8] color
    output logic [31:0]                  m_axis_tdata,
    // [0] lit
    output logic                         m_axis_tuser,
    output logic                         m_axis_tlast,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsps_pkg::APB_AW-1:0]  paddr,
    input  logic [lsps_pkg::APB_DW-1:0]  pwdata,
    output logic [lsps_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    localparam int PW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int LW = $clog2(MAX_LIGHTS + 1);
    localparam int SW = 20;
    localparam logic signed [SW-1:0] ONE = 1;

    // Configuration registers
    logic [lsps_pkg::LIGHTS_W-1:0] r_num_lights;
    logic [lsps_pkg::BLOCK_W-1:0]  r_block_left;
    logic [lsps_pkg::BLOCK_W-1:0]  r_block_right;
    logic [lsps_pkg::BCOUNT_W-1:0] r_blink_count;
    logic [lsps_pkg::BFRAME_W-1:0] r_blink_frames;
    logic [lsps_pkg::END_W-1:0]    r_end_frames;

    // Sequencer state
    lsps_pkg::t_phase              r_phase, n_phase;
    logic [lsps_pkg::FRAME_W-1:0]  r_frame, n_frame;
    logic [PW-1:0]                 r_position, n_position;
    logic [lsps_pkg::BFRAME_W-1:0] r_blink_sub, n_blink_sub;
    logic                          r_parity, n_parity;

    // Output register
    logic                          r_m_valid;
    logic [31:0]                   r_m_data;
    logic                          r_m_lit;
    logic                          r_m_last;

    logic                          w_cfg_wr;
    logic                          w_accept;
    logic [LW-1:0]                 w_eff_l;
    logic [lsps_pkg::BFRAME_W-1:0] w_period;
    logic [15:0]                   w_blink_len;
    logic signed [SW-1:0]          w_n, w_s, w_l, w_k1, w_k2, w_m, w_l1;
    logic                          w_in_left, w_in_right, w_in_cross_r;
    logic                          w_on, w_last;
    logic [lsps_pkg::FRAME_W:0]    w_f;
    logic [lsps_pkg::BFRAME_W:0]   w_sub_inc;
    logic [lsps_pkg::COLOR_W-1:0]  w_on_color, w_off_color;

    assign w_on_color  = s_axis_tdata[23:0];
    assign w_off_color = s_axis_tdata[47:24];

    // APB: always ready, write on the access cycle
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_lights   <= lsps_pkg::RST_NUM_LIGHTS;
            r_block_left   <= lsps_pkg::RST_BLOCK_LEFT;
            r_block_right  <= lsps_pkg::RST_BLOCK_RIGHT;
            r_blink_count  <= lsps_pkg::RST_BLINK_COUNT;
            r_blink_frames <= lsps_pkg::RST_BLINK_FRAME;
            r_end_frames   <= lsps_pkg::RST_END_FRAMES;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                lsps_pkg::REG_NUM_LIGHTS:  r_num_lights   <= pwdata[8:0];
                lsps_pkg::REG_BLOCK_LEFT:  r_block_left   <= pwdata[8:0];
                lsps_pkg::REG_BLOCK_RIGHT: r_block_right  <= pwdata[8:0];
                lsps_pkg::REG_BLINK_COUNT: r_blink_count  <= pwdata[7:0];
                lsps_pkg::REG_BLINK_FRAME: r_blink_frames <= pwdata[7:0];
                lsps_pkg::REG_END_FRAMES:  r_end_frames   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            lsps_pkg::REG_NUM_LIGHTS:  prdata = 32'(r_num_lights);
            lsps_pkg::REG_BLOCK_LEFT:  prdata = 32'(r_block_left);
            lsps_pkg::REG_BLOCK_RIGHT: prdata = 32'(r_block_right);
            lsps_pkg::REG_BLINK_COUNT: prdata = 32'(r_blink_count);
            lsps_pkg::REG_BLINK_FRAME: prdata = 32'(r_blink_frames);
            lsps_pkg::REG_END_FRAMES:  prdata = 32'(r_end_frames);
            default:                   prdata = '0;
        endcase
    end

    // Clamp the light count and the blink period
    always_comb begin
        if (r_num_lights == '0) begin
            w_eff_l = LW'(1);
        end else if (int'(r_num_lights) > MAX_LIGHTS) begin
            w_eff_l = LW'(MAX_LIGHTS);
        end else begin
            w_eff_l = LW'(r_num_lights);
        end
    end

    assign w_period    = (r_blink_frames == '0) ? lsps_pkg::BFRAME_W'(1) : r_blink_frames;
    assign w_blink_len = 16'(r_blink_count) * 16'(w_period);

    // Pattern geometry in signed arithmetic
    assign w_n  = SW'(r_position);
    assign w_s  = SW'(r_frame);
    assign w_l  = SW'(w_eff_l);
    assign w_k1 = SW'(r_block_left);
    assign w_k2 = SW'(r_block_right);
    assign w_l1 = w_l - ONE;
    assign w_m  = w_l1 - w_s;

    assign w_in_left    = (w_n >= w_s) && (w_n < w_s + w_k1);
    assign w_in_right   = (w_n <= w_m) && (w_n + w_k2 > w_m);
    assign w_in_cross_r = (w_n <= w_m) && (w_n + w_k1 > w_m);
    assign w_last       = (w_n >= w_l1);

    // Select lit state by phase
    always_comb begin
        unique case (r_phase)
            lsps_pkg::PH_LEFT:   w_on = w_in_left;
            lsps_pkg::PH_RIGHT:  w_on = w_in_right;
            lsps_pkg::PH_FILL_L: w_on = (w_n <= w_s);
            lsps_pkg::PH_CROSS:  w_on = w_in_left | w_in_cross_r;
            lsps_pkg::PH_FILL_R: w_on = (w_n >= w_m);
            lsps_pkg::PH_BLINK:  w_on = r_position[0] ^ r_parity;
            default:             w_on = 1'b0;
        endcase
    end

    // Advance position, frame and phase
    assign w_f       = {1'b0, r_frame} + 1'b1;
    assign w_sub_inc = {1'b0, r_blink_sub} + 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_frame     = r_frame;
        n_position  = r_position + 1'b1;
        n_blink_sub = r_blink_sub;
        n_parity    = r_parity;
        if (w_last) begin
            n_position = '0;
            unique case (r_phase)
                lsps_pkg::PH_LEFT, lsps_pkg::PH_RIGHT, lsps_pkg::PH_FILL_L,
                lsps_pkg::PH_CROSS, lsps_pkg::PH_FILL_R: begin
                    if (w_f >= (lsps_pkg::FRAME_W+1)'(w_eff_l)) begin
                        n_frame = '0;
                        unique case (r_phase)
                            lsps_pkg::PH_LEFT:   n_phase = lsps_pkg::PH_RIGHT;
                            lsps_pkg::PH_RIGHT:  n_phase = lsps_pkg::PH_FILL_L;
                            lsps_pkg::PH_FILL_L: n_phase = lsps_pkg::PH_CROSS;
                            lsps_pkg::PH_CROSS:  n_phase = lsps_pkg::PH_FILL_R;
                            default: begin
                                n_blink_sub = '0;
                                n_parity    = 1'b0;
                                if (r_blink_count != '0) begin
                                    n_phase = lsps_pkg::PH_BLINK;
                                end else if (r_end_frames != '0) begin
                                    n_phase = lsps_pkg::PH_END;
                                end else begin
                                    n_phase = lsps_pkg::PH_LEFT;
                                end
                            end
                        endcase
                    end else begin
                        n_frame = lsps_pkg::FRAME_W'(w_f);
                    end
                end
                lsps_pkg::PH_BLINK: begin
                    if (w_sub_inc >= (lsps_pkg::BFRAME_W+1)'(w_period)) begin
                        n_blink_sub = '0;
                        n_parity    = ~r_parity;
                    end else begin
                        n_blink_sub = lsps_pkg::BFRAME_W'(w_sub_inc);
                    end
                    if (w_f >= (lsps_pkg::FRAME_W+1)'(w_blink_len)) begin
                        n_frame = '0;
                        n_phase = (r_end_frames != '0) ? lsps_pkg::PH_END
                                                       : lsps_pkg::PH_LEFT;
                    end else begin
                        n_frame = lsps_pkg::FRAME_W'(w_f);
                    end
                end
                default: begin
                    if (w_f >= (lsps_pkg::FRAME_W+1)'(r_end_frames)) begin
                        n_frame = '0;
                        n_phase = lsps_pkg::PH_LEFT;
                    end else begin
                        n_frame = lsps_pkg::FRAME_W'(w_f);
                    end
                end
            endcase
        end
    end

    // Take a transfer when the output register is empty or draining
    assign s_axis_tready = ~r_m_valid | m_axis_tready;
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lsps_pkg::PH_LEFT;
            r_frame     <= '0;
            r_position  <= '0;
            r_blink_sub <= '0;
            r_parity    <= 1'b0;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_frame     <= n_frame;
            r_position  <= n_position;
            r_blink_sub <= n_blink_sub;
            r_parity    <= n_parity;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= {(w_on ? w_on_color : w_off_color),
                         lsps_pkg::INDEX_W'(r_position)};
            r_m_lit  <= w_on;
            r_m_last <= w_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_lit;
    assign m_axis_tlast  = r_m_last;

endmodule
